### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the latin square cipher block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that one condition implies another in the same cycle.
`define ASSERT_IMPLY(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

### hdl/lsae_pkg.sv
// ----------------------------------------------------------------------------
// lsae_pkg
// Types and constants shared by the latin square cipher modules.
// ----------------------------------------------------------------------------
package lsae_pkg;

    // Width of every byte field on the streams
    localparam int BYTE_W = 8;

    // Number of padding fields carried by an input transaction
    localparam int PAD_FIELDS = 3;

    // Input tdata layout, lowest bit first
    localparam int OFS_TBL_STATE  = 0;
    localparam int OFS_TBL_SIGNAL = 8;
    localparam int OFS_TBL_NEXT   = 16;
    localparam int OFS_PLAIN      = 24;
    localparam int OFS_PAD0       = 32;
    localparam int IN_DATA_W      = 56;

    // Request kinds carried in tuser
    localparam logic REQ_TBL_WRITE = 1'b0;
    localparam logic REQ_ENCRYPT   = 1'b1;

    // Pad count register
    localparam int         PAD_CNT_W       = 2;
    localparam logic [1:0] PAD_COUNT_RESET = 2'd3;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] sig;
        logic              last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } res_push_t;

endpackage

### hdl/lsae_tbl_ram.sv
// ----------------------------------------------------------------------------
// lsae_tbl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lsae_tbl_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rdata_reg;

    // Write on enable, read old contents on a same-cycle collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lsae_out_fifo.sv
// ----------------------------------------------------------------------------
// lsae_out_fifo
// Small result queue between the sequencer and the master stream.
// ----------------------------------------------------------------------------
module lsae_out_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lsae_pkg::res_push_t                 push,
    input  logic                                pop,
    output logic                                not_empty,
    output lsae_pkg::result_t                   head,
    output logic [lsae_pkg::FIFO_CNT_W-1:0]     count
);

    localparam int PTR_W = lsae_pkg::FIFO_PTR_W;
    localparam int CNT_W = lsae_pkg::FIFO_CNT_W;

    lsae_pkg::result_t mem [lsae_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign do_pop = pop && (count_reg != '0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push.valid, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.res;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

### hdl/lsae_seq.sv
// ----------------------------------------------------------------------------
// lsae_seq
// Step sequencer: holds the current item and state, issues table writes and reads,
// forwards read data into the next address, and forms result transactions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsae_seq #(
    parameter int SIGNAL_BITS = 8,
    parameter int MAX_PAD     = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [lsae_pkg::PAD_CNT_W-1:0]       cfg_data,
    // input items
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_user,
    input  logic [lsae_pkg::IN_DATA_W-1:0]       in_data,
    // result queue
    input  logic [lsae_pkg::FIFO_CNT_W-1:0]      fifo_count,
    output lsae_pkg::res_push_t                  push,
    // next-state table
    output logic                                 nt_we,
    output logic [2*SIGNAL_BITS-1:0]             nt_waddr,
    output logic [SIGNAL_BITS-1:0]               nt_wdata,
    output logic                                 nt_re,
    output logic [2*SIGNAL_BITS-1:0]             nt_raddr,
    input  logic [SIGNAL_BITS-1:0]               nt_rdata,
    // inverse table
    output logic                                 it_we,
    output logic [2*SIGNAL_BITS-1:0]             it_waddr,
    output logic [SIGNAL_BITS-1:0]               it_wdata,
    output logic                                 it_re,
    output logic [2*SIGNAL_BITS-1:0]             it_raddr,
    input  logic [SIGNAL_BITS-1:0]               it_rdata
);

    localparam int SB     = SIGNAL_BITS;
    localparam int BW     = lsae_pkg::BYTE_W;
    localparam int CNT_W  = $clog2(MAX_PAD + 1);
    localparam int PIDX_W = (MAX_PAD > 1) ? $clog2(MAX_PAD) : 1;
    localparam int FCNT_W = lsae_pkg::FIFO_CNT_W;

    // Input fields, masked to the signal width
    logic [SB-1:0] f_state, f_signal, f_next, f_plain;
    logic [SB-1:0] pad_in [lsae_pkg::PAD_FIELDS];

    logic [lsae_pkg::PAD_CNT_W-1:0] pad_count_reg;
    logic                           busy_reg;
    logic [CNT_W-1:0]               idx_reg;
    logic [CNT_W-1:0]               pads_reg;
    logic [SB-1:0]                  plain_reg;
    logic [SB-1:0]                  pad_reg [MAX_PAD];
    logic [SB-1:0]                  state_reg;
    logic                           pend_pad_reg;
    logic                           inflight_reg;
    logic                           last_reg;
    logic [SB-1:0]                  sig_reg;

    logic             accept, wr_acc, enc_acc;
    logic             space, issue, is_final, pad_issue, fin_issue;
    logic [CNT_W-1:0] pads_in;
    logic [SB-1:0]    row, cur_pad;

    // Unpack the input transaction
    always_comb
    begin
        f_state  = SB'(in_data[lsae_pkg::OFS_TBL_STATE  +: BW]);
        f_signal = SB'(in_data[lsae_pkg::OFS_TBL_SIGNAL +: BW]);
        f_next   = SB'(in_data[lsae_pkg::OFS_TBL_NEXT   +: BW]);
        f_plain  = SB'(in_data[lsae_pkg::OFS_PLAIN      +: BW]);
        for (int i = 0; i < lsae_pkg::PAD_FIELDS; i++)
        begin
            pad_in[i] = SB'(in_data[lsae_pkg::OFS_PAD0 + BW*i +: BW]);
        end
    end

    // Clamp the pad count to what the block stores
    assign pads_in = (int'(pad_count_reg) > MAX_PAD) ? CNT_W'(MAX_PAD)
                                                     : CNT_W'(pad_count_reg);

    // Issue a step only when the queue has room for its result
    assign space     = (fifo_count + FCNT_W'(inflight_reg)) < FCNT_W'(lsae_pkg::FIFO_DEPTH);
    assign issue     = busy_reg && space;
    assign is_final  = (idx_reg == pads_reg);
    assign pad_issue = issue && !is_final;
    assign fin_issue = issue && is_final;

    // Take the next item while the closing step of this one issues
    assign in_ready = !busy_reg || fin_issue;
    assign accept   = in_valid && in_ready;
    assign wr_acc   = accept && (in_user == lsae_pkg::REQ_TBL_WRITE);
    assign enc_acc  = accept && (in_user == lsae_pkg::REQ_ENCRYPT);

    // Forward fresh next-state data straight into the read address
    assign row     = pend_pad_reg ? nt_rdata : state_reg;
    assign cur_pad = pad_reg[idx_reg[PIDX_W-1:0]];

    // Table writes: forward entry and inverse entry
    assign nt_we    = wr_acc;
    assign nt_waddr = {f_state, f_signal};
    assign nt_wdata = f_next;
    assign it_we    = wr_acc;
    assign it_waddr = {f_state, f_next};
    assign it_wdata = f_signal;

    // Table reads for padding and closing steps
    assign nt_re    = pad_issue;
    assign nt_raddr = {row, cur_pad};
    assign it_re    = fin_issue;
    assign it_raddr = {row, plain_reg};

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_count_reg <= lsae_pkg::PAD_COUNT_RESET;
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            state_reg     <= '0;
            pend_pad_reg  <= 1'b0;
            inflight_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pad_count_reg <= cfg_data;
            end
            if (enc_acc)
            begin
                busy_reg <= 1'b1;
            end
            else if (fin_issue)
            begin
                busy_reg <= 1'b0;
            end
            if (enc_acc)
            begin
                idx_reg <= '0;
            end
            else if (pad_issue)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            // Closing step lands on the plaintext byte; padding walks the table
            if (fin_issue)
            begin
                state_reg <= plain_reg;
            end
            else if (pend_pad_reg)
            begin
                state_reg <= nt_rdata;
            end
            pend_pad_reg <= pad_issue;
            inflight_reg <= issue;
        end
    end

    // Item and step payload
    always_ff @(posedge clk)
    begin
        if (enc_acc)
        begin
            pads_reg  <= pads_in;
            plain_reg <= f_plain;
            for (int i = 0; i < MAX_PAD; i++)
            begin
                pad_reg[i] <= pad_in[i];
            end
        end
        if (issue)
        begin
            last_reg <= fin_issue;
            sig_reg  <= cur_pad;
        end
    end

    // Result transaction in the cycle after its step issues
    always_comb
    begin
        push.valid    = inflight_reg;
        push.res.last = last_reg;
        push.res.sig  = last_reg ? BW'(it_rdata) : BW'(sig_reg);
    end

    `ASSERT_CLK(a_queue_credit, (fifo_count + FCNT_W'(inflight_reg)) <= FCNT_W'(lsae_pkg::FIFO_DEPTH), "result queue overrun")
    `ASSERT_CLK(a_final_push, fin_issue |=> (push.valid && push.res.last), "closing step lost its result")
    `ASSERT_CLK(a_pad_push, pad_issue |=> (push.valid && !push.res.last), "padding step lost its result")
    `ASSERT_IMPLY(a_pad_in_range, pad_issue, (idx_reg < pads_reg), "padding step past pad count")

endmodule

### hdl/latin_square_automaton_encrypt_top.sv
// ----------------------------------------------------------------------------
// latin_square_automaton_encrypt_top
// Latin square automaton cipher, encrypting side, with table loading.
//
//   Channel   Direction  Fields (low bit first)
//   s_*       in         tuser: req_type; tdata: tbl_state, tbl_signal,
//                        tbl_next, plain_byte, pad_sig0..pad_sig2
//   m_*       out        tdata: cipher_sig; tlast: last
//   cfg_*     in         cfg_data: pad_count (write when cfg_we)
//
// An encrypt transaction reads the next-state memory min(pad_count, MAX_PAD)
// times, then the inverse memory once, each dependent on the current state.
// A table write transaction writes both memories when accepted. Tables are
// not cleared at reset; reset restores the state to zero and pad_count to 3.
// A master-side stall fills a four-deep result queue, then steps pause.
// ----------------------------------------------------------------------------
module latin_square_automaton_encrypt_top #(
    parameter int SIGNAL_BITS = 8,
    parameter int MAX_PAD     = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tbl_state, tbl_signal, tbl_next, plain_byte, pad_sig0, pad_sig1, pad_sig2
    input  logic [lsae_pkg::IN_DATA_W-1:0]      s_tdata,
    // req_type
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cipher_sig
    output logic [lsae_pkg::BYTE_W-1:0]         m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [lsae_pkg::PAD_CNT_W-1:0]      cfg_data
);

    localparam int SB = SIGNAL_BITS;
    localparam int AW = 2 * SIGNAL_BITS;

    lsae_pkg::res_push_t                 push;
    lsae_pkg::result_t                   head;
    logic [lsae_pkg::FIFO_CNT_W-1:0]     fifo_count;

    logic          nt_we, nt_re, it_we, it_re;
    logic [AW-1:0] nt_waddr, nt_raddr, it_waddr, it_raddr;
    logic [SB-1:0] nt_wdata, nt_rdata, it_wdata, it_rdata;

    // Sequencer
    lsae_seq #(
        .SIGNAL_BITS (SIGNAL_BITS),
        .MAX_PAD     (MAX_PAD)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_user    (s_tuser),
        .in_data    (s_tdata),
        .fifo_count (fifo_count),
        .push       (push),
        .nt_we      (nt_we),
        .nt_waddr   (nt_waddr),
        .nt_wdata   (nt_wdata),
        .nt_re      (nt_re),
        .nt_raddr   (nt_raddr),
        .nt_rdata   (nt_rdata),
        .it_we      (it_we),
        .it_waddr   (it_waddr),
        .it_wdata   (it_wdata),
        .it_re      (it_re),
        .it_raddr   (it_raddr),
        .it_rdata   (it_rdata)
    );

    // Next-state table: (state, signal) -> next state
    lsae_tbl_ram #(
        .ADDR_W (AW),
        .DATA_W (SB)
    ) u_next_ram (
        .clk   (clk),
        .we    (nt_we),
        .waddr (nt_waddr),
        .wdata (nt_wdata),
        .re    (nt_re),
        .raddr (nt_raddr),
        .rdata (nt_rdata)
    );

    // Inverse table: (state, target) -> signal
    lsae_tbl_ram #(
        .ADDR_W (AW),
        .DATA_W (SB)
    ) u_inv_ram (
        .clk   (clk),
        .we    (it_we),
        .waddr (it_waddr),
        .wdata (it_wdata),
        .re    (it_re),
        .raddr (it_raddr),
        .rdata (it_rdata)
    );

    // Result queue toward the master stream
    lsae_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (fifo_count)
    );

    assign m_tdata = head.sig;
    assign m_tlast = head.last;

endmodule

### tb/latin_square_automaton_encrypt_top_tb.sv
// ----------------------------------------------------------------------------
// latin_square_automaton_encrypt_top_tb
// Self-checking bench for the latin square automaton cipher, encrypting side.
//
// Table-write and encrypt transactions go in on the slave stream. A predictor
// in the bench keeps its own copy of the next-state and inverse tables, the
// automaton state and pad_count, and queues the cipher signals that each
// encrypt must produce. Every transaction on the master stream is compared
// with the oldest queued signal. Before each encrypt the bench loads any
// table entry the walk would touch that has never been written, so the block
// never reads an undefined entry. Directed cases come first, then random
// phases with different pad counts and idle profiles, then a long hold-off on
// the output stream that backs the block up into its input.
// ----------------------------------------------------------------------------
module latin_square_automaton_encrypt_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 9;
    localparam int SIG_BITS       = 8;
    localparam int PAD_LIMIT      = 3;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_CYCLES = 200_000;

    typedef logic [lsae_pkg::BYTE_W-1:0] byte_t;
    typedef logic [lsae_pkg::PAD_FIELDS-1:0][lsae_pkg::BYTE_W-1:0] pad_set_t;

    // DUT ports
    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // tbl_state, tbl_signal, tbl_next, plain_byte, pad_sig0, pad_sig1, pad_sig2
    logic [lsae_pkg::IN_DATA_W-1:0]    s_tdata  = '0;
    // req_type
    logic                              s_tuser  = lsae_pkg::REQ_TBL_WRITE;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // cipher_sig
    logic [lsae_pkg::BYTE_W-1:0]       m_tdata;
    logic                              m_tlast;
    logic                              cfg_we   = 1'b0;
    logic [lsae_pkg::PAD_CNT_W-1:0]    cfg_data = lsae_pkg::PAD_COUNT_RESET;

    // Predictor state
    logic [lsae_pkg::PAD_CNT_W-1:0]    pad_setting;
    byte_t                             auto_state;
    byte_t                             next_state_tbl  [0:65535];
    byte_t                             inverse_sig_tbl [0:65535];
    bit                                next_written    [0:65535];
    bit                                inverse_written [0:65535];
    lsae_pkg::result_t                 cipher_expected [$];

    // Idle profile and long output hold request
    int                     tx_idle_pct  = 0;
    int                     rx_stall_pct = 0;
    logic                   hold_req     = 1'b0;
    logic                   hold_ack     = 1'b0;
    int                     hold_left    = 0;

    // Run statistics
    int                     mismatches      = 0;
    int                     items_sent      = 0;
    int                     writes_sent     = 0;
    int                     encrypts_sent   = 0;
    int                     results_checked = 0;

    latin_square_automaton_encrypt_top #(
        .SIGNAL_BITS(SIG_BITS),
        .MAX_PAD    (PAD_LIMIT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int pads_used();
        return (pad_setting > PAD_LIMIT) ? PAD_LIMIT : int'(pad_setting);
    endfunction

    // Apply one accepted transaction and queue the signals it must produce
    function automatic void advance_cipher(input logic kind,
                                           input logic [lsae_pkg::IN_DATA_W-1:0] data);
        byte_t             row, col, dst, sig, target;
        lsae_pkg::result_t res;
        int                i;
        items_sent++;
        if (kind == lsae_pkg::REQ_TBL_WRITE)
        begin
            row = data[lsae_pkg::OFS_TBL_STATE  +: lsae_pkg::BYTE_W];
            col = data[lsae_pkg::OFS_TBL_SIGNAL +: lsae_pkg::BYTE_W];
            dst = data[lsae_pkg::OFS_TBL_NEXT   +: lsae_pkg::BYTE_W];
            next_state_tbl[{row, col}]  = dst;
            next_written[{row, col}]    = 1'b1;
            inverse_sig_tbl[{row, dst}] = col;
            inverse_written[{row, dst}] = 1'b1;
            writes_sent++;
        end
        else
        begin
            for (i = 0; i < pads_used(); i++)
            begin
                sig        = data[lsae_pkg::OFS_PAD0 + lsae_pkg::BYTE_W * i +: lsae_pkg::BYTE_W];
                auto_state = next_state_tbl[{auto_state, sig}];
                res.sig    = sig;
                res.last   = 1'b0;
                cipher_expected.push_back(res);
            end
            target     = data[lsae_pkg::OFS_PLAIN +: lsae_pkg::BYTE_W];
            res.sig    = inverse_sig_tbl[{auto_state, target}];
            res.last   = 1'b1;
            cipher_expected.push_back(res);
            auto_state = target;
            encrypts_sent++;
        end
    endfunction

    // Find a written column of a row, starting at a random column
    function automatic byte_t pick_column(input byte_t row, input bit inverse);
        byte_t start, col;
        int    k;
        start = byte_t'($urandom);
        for (k = 0; k < 256; k++)
        begin
            col = start + byte_t'(k);
            if (inverse ? inverse_written[{row, col}] : next_written[{row, col}])
                return col;
        end
        return start;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Offer one transaction, hold it until accepted, then predict
    task automatic send_item(input logic kind, input logic [lsae_pkg::IN_DATA_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_cipher(kind, data);
    endtask

    task automatic send_table_write(input byte_t row, input byte_t col, input byte_t dst);
        send_item(lsae_pkg::REQ_TBL_WRITE,
                  {pad_set_t'($urandom), byte_t'($urandom), dst, col, row});
    endtask

    // Load every entry the walk would read that was never written, then encrypt
    task automatic encrypt_byte(input byte_t plain, input pad_set_t pads);
        byte_t walk;
        int    i;
        bit    hole, ready;
        ready = 1'b0;
        while (!ready)
        begin
            walk = auto_state;
            hole = 1'b0;
            for (i = 0; i < pads_used() && !hole; i++)
            begin
                if (!next_written[{walk, pads[i]}])
                begin
                    hole = 1'b1;
                    send_table_write(walk, pads[i], byte_t'($urandom));
                end
                else
                    walk = next_state_tbl[{walk, pads[i]}];
            end
            if (!hole)
            begin
                if (inverse_written[{walk, plain}])
                    ready = 1'b1;
                else
                    send_table_write(walk, byte_t'($urandom), plain);
            end
        end
        send_item(lsae_pkg::REQ_ENCRYPT, {pads, plain, byte_t'($urandom), byte_t'($urandom),
                                          byte_t'($urandom)});
    endtask

    // Random encrypt that mostly follows known entries, or a stray table write
    task automatic send_random_item(input int noise_pct);
        pad_set_t pads;
        byte_t    plain, walk;
        int       i;
        bit       lost;
        pads = pad_set_t'($urandom);
        if ($urandom_range(99) < noise_pct)
        begin
            send_table_write(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
            return;
        end
        walk = auto_state;
        lost = 1'b0;
        for (i = 0; i < pads_used(); i++)
        begin
            if (!lost && $urandom_range(3) != 0)
                pads[i] = pick_column(walk, 1'b0);
            if (next_written[{walk, pads[i]}])
                walk = next_state_tbl[{walk, pads[i]}];
            else
                lost = 1'b1;
        end
        plain = (!lost && $urandom_range(1) != 0) ? pick_column(walk, 1'b1)
                                                 : byte_t'($urandom);
        encrypt_byte(plain, pads);
    endtask

    // Drop valid and wait until every pending signal has come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (cipher_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_pad_count(input logic [lsae_pkg::PAD_CNT_W-1:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        pad_setting = value;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        // Reset value of pad_count is in force here
        send_table_write(8'h00, 8'h00, 8'h00);
        send_table_write(8'hFF, 8'hFF, 8'hFF);
        send_table_write(8'h00, 8'hFF, 8'hFF);
        encrypt_byte(8'h00, '0);
        encrypt_byte(8'hFF, '1);
        encrypt_byte(8'h00, 24'h00FF00);
        // Overwritten next-state entry: the later write sets the path
        set_pad_count(2'd1);
        send_table_write(auto_state, 8'h3C, 8'h01);
        send_table_write(auto_state, 8'h3C, 8'hFE);
        encrypt_byte(8'hC3, 24'hFFFF3C);
        // Two writes to the same inverse entry: the later signal wins
        set_pad_count(2'd0);
        send_table_write(auto_state, 8'h11, 8'h5A);
        send_table_write(auto_state, 8'h22, 8'h5A);
        encrypt_byte(8'h5A, '1);
        set_pad_count(2'd2);
        encrypt_byte(8'h80, 24'h7F0180);
        set_pad_count(2'd3);
        encrypt_byte(8'h01, 24'hA55AC3);
    endtask

    task automatic test_random_traffic(input logic [lsae_pkg::PAD_CNT_W-1:0] pads,
                                       input int tx_pct, input int rx_pct, input int count);
        int goal;
        set_pad_count(pads);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        goal = items_sent + count;
        while (items_sent < goal)
            send_random_item(20);
        wait_idle();
    endtask

    // Hold the output off while encrypts keep coming, so the input stalls
    task automatic test_output_hold();
        int i;
        set_pad_count(2'd3);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req <= ~hold_req;
        for (i = 0; i < 20; i++)
            send_random_item(0);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready with random stalls, long hold counted here
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("ERROR at %0t ns: %s expected %0h got %0h", $time, what, want, got);
        mismatches++;
    endtask

    // Compare each output transaction with the oldest pending signal
    always @(posedge clk)
    begin
        lsae_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cipher_expected.size() == 0)
                report_mismatch("unrequested cipher_sig", 0, m_tdata);
            else
            begin
                want = cipher_expected.pop_front();
                if (m_tdata !== want.sig)
                    report_mismatch("cipher_sig", want.sig, m_tdata);
                if (m_tlast !== want.last)
                    report_mismatch("last", want.last, m_tlast);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        pad_setting = lsae_pkg::PAD_COUNT_RESET;
        auto_state  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(2'd3, 0, 0, 90);
        test_random_traffic(2'd1, 48, 0, 90);
        test_random_traffic(2'd0, 0, 48, 85);
        test_random_traffic(2'd2, 30, 30, 85);
        test_output_hold();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Run covered %0d transactions: %0d table writes, %0d encrypted bytes",
                 items_sent, writes_sent, encrypts_sent);
        $display("Checked %0d cipher signals over pad counts 0-3, four idle profiles,",
                 results_checked);
        $display("and a %0d-cycle output hold", HOLD_CYCLES);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Bound the run
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Timeout with %0d cipher signals pending", cipher_expected.size());
        $display("FAILURE");
        $finish;
    end

endmodule
